FILE: design/linked_slot_pool_allocator_top_defines.svh
// assertion macros shared by the slot pool allocator modules
// no dependencies; each macro samples on clk and is disabled while rst is high
`ifndef LINKED_SLOT_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define LINKED_SLOT_POOL_ALLOCATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every edge
`define LSPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define LSPA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LSPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LSPA_ASSERT(lbl, prop, msg)
`define LSPA_ASSERT_IMPL(lbl, ante, cons, msg)
`define LSPA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/lspa_pkg.sv
// shared types and constants for the linked slot pool allocator
// no dependencies; used by lspa_ctrl, lspa_dp and the top level
package lspa_pkg;

  // pool geometry
  localparam int SLOTS      = 32;
  localparam int ADDR_W     = $clog2(SLOTS);
  localparam int LINK_W     = $clog2(SLOTS + 1);
  localparam logic [LINK_W-1:0] LIST_END = LINK_W'(SLOTS);

  // word field widths
  localparam int SLOT_NUM_W = 5;
  localparam int HEAD_W     = 6;
  localparam int STATUS_W   = 2;

  // request codes
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_EXHAUSTED   = 2'd1,
    ST_NONE_IN_USE = 2'd2,
    ST_NOT_FOUND   = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_WR,
    S_WALK,
    S_FREE_PUSH,
    S_FINISH
  } state_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ALLOC_RD,
    OP_ALLOC_WR,
    OP_WALK_START,
    OP_WALK_ADV,
    OP_UNLINK,
    OP_FREE_PUSH,
    OP_SET_STATUS
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    dp_op_t  op;
    status_t status;
    logic    load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic action;
    logic free_empty;
    logic used_empty;
    logic found;
    logic can_adv;
  } dp_sts_t;

endpackage

FILE: design/lspa_dp.sv
// datapath of the slot pool allocator: list heads, link store, walk registers
// depends on lspa_pkg and linked_slot_pool_allocator_top_defines.svh
`include "linked_slot_pool_allocator_top_defines.svh"

module lspa_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  lspa_pkg::dp_cmd_t               cmd,
  output lspa_pkg::dp_sts_t               sts,
  input  logic                            action,
  input  logic [lspa_pkg::SLOT_NUM_W-1:0] slot_number,
  output logic [lspa_pkg::STATUS_W-1:0]   status,
  output logic [lspa_pkg::SLOT_NUM_W-1:0] granted_slot,
  output logic [lspa_pkg::HEAD_W-1:0]     first_in_use
);

  // list heads
  logic [lspa_pkg::LINK_W-1:0] free_head;
  logic [lspa_pkg::LINK_W-1:0] in_use_head;

  // captured request
  logic                            act;
  logic [lspa_pkg::SLOT_NUM_W-1:0] target;

  // walk registers
  logic [lspa_pkg::LINK_W-1:0] cur;
  logic [lspa_pkg::LINK_W-1:0] prev;
  logic [lspa_pkg::LINK_W-1:0] steps;

  // pending result
  lspa_pkg::status_t               res_status;
  logic [lspa_pkg::SLOT_NUM_W-1:0] res_granted;

  // link store with per-entry written flags
  logic [lspa_pkg::LINK_W-1:0] link_mem [lspa_pkg::SLOTS];
  logic [lspa_pkg::SLOTS-1:0]  link_written;
  logic                        rd_en;
  logic [lspa_pkg::ADDR_W-1:0] rd_addr;
  logic [lspa_pkg::LINK_W-1:0] rd_q;
  logic [lspa_pkg::ADDR_W-1:0] rd_addr_q;
  logic                        rd_written_q;
  logic [lspa_pkg::LINK_W-1:0] link;
  logic                        wr_en;
  logic [lspa_pkg::ADDR_W-1:0] wr_addr;
  logic [lspa_pkg::LINK_W-1:0] wr_data;
  logic                        target_ok;

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = free_head[lspa_pkg::ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = free_head[lspa_pkg::ADDR_W-1:0];
    wr_data = in_use_head;
    case (cmd.op)
      lspa_pkg::OP_ALLOC_RD: begin
        rd_en = 1'b1;
      end
      lspa_pkg::OP_WALK_START: begin
        rd_en   = 1'b1;
        rd_addr = in_use_head[lspa_pkg::ADDR_W-1:0];
      end
      lspa_pkg::OP_WALK_ADV: begin
        rd_en   = 1'b1;
        rd_addr = link[lspa_pkg::ADDR_W-1:0];
      end
      lspa_pkg::OP_ALLOC_WR: begin
        wr_en = 1'b1;
      end
      lspa_pkg::OP_UNLINK: begin
        wr_en   = (prev != lspa_pkg::LIST_END);
        wr_addr = prev[lspa_pkg::ADDR_W-1:0];
        wr_data = link;
      end
      lspa_pkg::OP_FREE_PUSH: begin
        wr_en   = 1'b1;
        wr_addr = cur[lspa_pkg::ADDR_W-1:0];
        wr_data = free_head;
      end
      default: begin
      end
    endcase
  end

  // link store write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
  end

  // written flags, cleared at reset so untouched entries read as index plus one
  always_ff @(posedge clk) begin
    if (rst) begin
      link_written <= '0;
    end else if (wr_en) begin
      link_written[wr_addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q         <= link_mem[rd_addr];
      rd_addr_q    <= rd_addr;
      rd_written_q <= link_written[rd_addr];
    end
  end

  assign link = rd_written_q ? rd_q
                             : lspa_pkg::LINK_W'(rd_addr_q) + lspa_pkg::LINK_W'(1);

  // list heads
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head   <= '0;
      in_use_head <= lspa_pkg::LIST_END;
    end else begin
      case (cmd.op)
        lspa_pkg::OP_ALLOC_WR: begin
          free_head   <= link;
          in_use_head <= free_head;
        end
        lspa_pkg::OP_UNLINK: begin
          if (prev == lspa_pkg::LIST_END) begin
            in_use_head <= link;
          end
        end
        lspa_pkg::OP_FREE_PUSH: begin
          free_head <= cur;
        end
        default: begin
        end
      endcase
    end
  end

  // request capture, walk registers and pending result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act    <= action;
      target <= slot_number;
    end
    case (cmd.op)
      lspa_pkg::OP_WALK_START: begin
        cur   <= in_use_head;
        prev  <= lspa_pkg::LIST_END;
        steps <= '0;
      end
      lspa_pkg::OP_WALK_ADV: begin
        prev  <= cur;
        cur   <= link;
        steps <= steps + lspa_pkg::LINK_W'(1);
      end
      lspa_pkg::OP_ALLOC_WR: begin
        res_status  <= lspa_pkg::ST_OK;
        res_granted <= lspa_pkg::SLOT_NUM_W'(free_head);
      end
      lspa_pkg::OP_FREE_PUSH: begin
        res_status  <= lspa_pkg::ST_OK;
        res_granted <= '0;
      end
      lspa_pkg::OP_SET_STATUS: begin
        res_status  <= cmd.status;
        res_granted <= '0;
      end
      default: begin
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= res_status;
      granted_slot <= res_granted;
      first_in_use <= lspa_pkg::HEAD_W'(in_use_head);
    end
  end

  // status toward the controller
  assign target_ok      = (32'(target) < 32'(lspa_pkg::SLOTS));
  assign sts.action     = act;
  assign sts.free_empty = (free_head >= lspa_pkg::LIST_END);
  assign sts.used_empty = (in_use_head >= lspa_pkg::LIST_END);
  assign sts.found      = (cur < lspa_pkg::LIST_END) && target_ok
                          && (cur == lspa_pkg::LINK_W'(target));
  assign sts.can_adv    = (cur < lspa_pkg::LIST_END) && (steps < lspa_pkg::LIST_END);

  // every slot sits on one of the two lists, so both cannot be empty
  `LSPA_ASSERT(a_lists_not_both_empty, !(sts.free_empty && sts.used_empty), "both lists empty")
  // the walk never goes past the pool size
  `LSPA_ASSERT_IMPL(a_walk_bounded, cmd.op == lspa_pkg::OP_WALK_ADV, steps < lspa_pkg::LIST_END, "walk overrun")
  // a list head never points into the pool past its end
  `LSPA_ASSERT(a_heads_in_range, (free_head <= lspa_pkg::LIST_END) && (in_use_head <= lspa_pkg::LIST_END), "head out of range")

endmodule

FILE: design/lspa_ctrl.sv
// controller state machine of the slot pool allocator and output valid flag
// depends on lspa_pkg and linked_slot_pool_allocator_top_defines.svh
`include "linked_slot_pool_allocator_top_defines.svh"

module lspa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lspa_pkg::dp_sts_t sts,
  output lspa_pkg::dp_cmd_t cmd
);

  lspa_pkg::state_t state;
  lspa_pkg::state_t state_next;
  logic             out_valid_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lspa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    cmd.capture  = 1'b0;
    cmd.op       = lspa_pkg::OP_NONE;
    cmd.status   = lspa_pkg::ST_OK;
    cmd.load_out = 1'b0;
    case (state)
      lspa_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = lspa_pkg::S_DISPATCH;
        end
      end
      lspa_pkg::S_DISPATCH: begin
        if (sts.action == lspa_pkg::ACT_ALLOC) begin
          if (sts.free_empty) begin
            cmd.op     = lspa_pkg::OP_SET_STATUS;
            cmd.status = lspa_pkg::ST_EXHAUSTED;
            state_next = lspa_pkg::S_FINISH;
          end else begin
            cmd.op     = lspa_pkg::OP_ALLOC_RD;
            state_next = lspa_pkg::S_ALLOC_WR;
          end
        end else begin
          if (sts.used_empty) begin
            cmd.op     = lspa_pkg::OP_SET_STATUS;
            cmd.status = lspa_pkg::ST_NONE_IN_USE;
            state_next = lspa_pkg::S_FINISH;
          end else begin
            cmd.op     = lspa_pkg::OP_WALK_START;
            state_next = lspa_pkg::S_WALK;
          end
        end
      end
      lspa_pkg::S_ALLOC_WR: begin
        cmd.op     = lspa_pkg::OP_ALLOC_WR;
        state_next = lspa_pkg::S_FINISH;
      end
      // one link per cycle
      lspa_pkg::S_WALK: begin
        if (sts.found) begin
          cmd.op     = lspa_pkg::OP_UNLINK;
          state_next = lspa_pkg::S_FREE_PUSH;
        end else if (sts.can_adv) begin
          cmd.op = lspa_pkg::OP_WALK_ADV;
        end else begin
          cmd.op     = lspa_pkg::OP_SET_STATUS;
          cmd.status = lspa_pkg::ST_NOT_FOUND;
          state_next = lspa_pkg::S_FINISH;
        end
      end
      lspa_pkg::S_FREE_PUSH: begin
        cmd.op     = lspa_pkg::OP_FREE_PUSH;
        state_next = lspa_pkg::S_FINISH;
      end
      // wait for the output register to free up
      lspa_pkg::S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = lspa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lspa_pkg::S_IDLE;
      end
    endcase
  end

  // output valid flag
  assign out_valid_next = cmd.load_out || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // an accepted word always starts a dispatch
  `LSPA_ASSERT_NEXT(a_accept_dispatch, in_valid && !in_stall, state == lspa_pkg::S_DISPATCH, "accept without dispatch")
  // a new result only appears out of the finish state
  `LSPA_ASSERT_IMPL(a_rise_from_finish, $rose(out_valid), $past(state) == lspa_pkg::S_FINISH, "result from wrong state")
  // a finished result waits while the previous one is still stalled
  `LSPA_ASSERT_NEXT(a_finish_holds, (state == lspa_pkg::S_FINISH) && out_valid && out_stall, state == lspa_pkg::S_FINISH, "result overwritten")

endmodule

FILE: design/linked_slot_pool_allocator_top.sv
// Linked slot pool allocator: hands out and takes back numbered slots
// (0 to 31) kept on a free list and an in-use list that share one link store.
// Input channel: in_valid / in_stall carrying action (0 allocate, 1 release)
// and slot_number (used by release only). Output channel: out_valid /
// out_stall carrying status, granted_slot and first_in_use (32 = none in use).
// One input word gives exactly one output word, in order.
// The walk reads the link store once per cycle through its single
// registered read port, which sets the release time.
// Words are taken one at a time: in_stall is high from the accept until the
// result has been moved into the output register.
// Reset puts all slots on the free list in order and empties the in-use list,
// with no clearing sweep.
// While out_stall holds a result, the next word is still accepted and worked
// on; it then waits until the output register is taken.
// depends on lspa_pkg, lspa_ctrl and lspa_dp
module linked_slot_pool_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic [lspa_pkg::SLOT_NUM_W-1:0] slot_number,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lspa_pkg::STATUS_W-1:0]   status,
  output logic [lspa_pkg::SLOT_NUM_W-1:0] granted_slot,
  output logic [lspa_pkg::HEAD_W-1:0]     first_in_use
);

  lspa_pkg::dp_cmd_t cmd;
  lspa_pkg::dp_sts_t sts;

  // sequencer
  lspa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // lists and link store
  lspa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .action       (action),
    .slot_number  (slot_number),
    .status       (status),
    .granted_slot (granted_slot),
    .first_in_use (first_in_use)
  );

endmodule

FILE: dv/slot_pool_checker.sv
// checker for the linked slot pool allocator: keeps its own copy of both lists,
// predicts one result word per accepted request word and compares in order
// depends on lspa_pkg
module slot_pool_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            action,
  input  logic [lspa_pkg::SLOT_NUM_W-1:0] slot_number,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [lspa_pkg::STATUS_W-1:0]   status,
  input  logic [lspa_pkg::SLOT_NUM_W-1:0] granted_slot,
  input  logic [lspa_pkg::HEAD_W-1:0]     first_in_use,
  output int                              fails,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lspa_pkg::*;

  typedef struct packed {
    status_t               st;
    logic [SLOT_NUM_W-1:0] slot;
    logic [HEAD_W-1:0]     head;
  } slot_result_t;

  // shadow of the pool: shared link store and the two list heads
  logic [LINK_W-1:0] link_store [SLOTS];
  logic [LINK_W-1:0] used_head;
  logic [LINK_W-1:0] free_head;
  slot_result_t      results_due [$];

  function automatic void reset_pool();
    for (int i = 0; i < SLOTS; i++) link_store[i] = LINK_W'(i + 1);
    used_head = LIST_END;
    free_head = '0;
  endfunction

  // apply one request to the shadow lists and return the word it must produce
  function automatic slot_result_t pool_step(input logic act,
                                             input logic [SLOT_NUM_W-1:0] target);
    slot_result_t      r;
    logic [LINK_W-1:0] grant;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] cur;
    int                hops;
    r.st   = ST_OK;
    r.slot = '0;
    if (act == ACT_ALLOC) begin
      // pop free head, push it on the in-use list
      if (free_head >= LIST_END) begin
        r.st = ST_EXHAUSTED;
      end else begin
        grant = free_head;
        free_head = link_store[grant[ADDR_W-1:0]];
        link_store[grant[ADDR_W-1:0]] = used_head;
        used_head = grant;
        r.slot = grant[SLOT_NUM_W-1:0];
      end
    end else if (used_head >= LIST_END) begin
      r.st = ST_NONE_IN_USE;
    end else begin
      // walk the in-use list, end-of-list tested before each read
      prev = LIST_END;
      cur  = used_head;
      hops = 0;
      while (cur < LIST_END && cur != LINK_W'(target) && hops < SLOTS) begin
        prev = cur;
        cur  = link_store[cur[ADDR_W-1:0]];
        hops++;
      end
      if (cur >= LIST_END || cur != LINK_W'(target)) begin
        r.st = ST_NOT_FOUND;
      end else begin
        // unlink and push on the free list
        if (prev >= LIST_END) used_head = link_store[cur[ADDR_W-1:0]];
        else link_store[prev[ADDR_W-1:0]] = link_store[cur[ADDR_W-1:0]];
        link_store[cur[ADDR_W-1:0]] = free_head;
        free_head = cur;
      end
    end
    r.head = used_head;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (fails < 40) $display("%0t ns mismatch: %s", $time, what);
    fails++;
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin : watch
    slot_result_t want;
    if (rst) begin
      reset_pool();
      results_due.delete();
      fails = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("result word with no request waiting");
        end else begin
          want = results_due.pop_front();
          if (status !== want.st)
            report_mismatch($sformatf("status got %0d want %0d", status, want.st));
          if (granted_slot !== want.slot)
            report_mismatch($sformatf("granted_slot got %0d want %0d",
                                      granted_slot, want.slot));
          if (first_in_use !== want.head)
            report_mismatch($sformatf("first_in_use got %0d want %0d",
                                      first_in_use, want.head));
        end
      end
      if (in_valid && !in_stall) results_due.push_back(pool_step(action, slot_number));
    end
    pending <= results_due.size();
  end

endmodule

FILE: dv/tb_linked_slot_pool_allocator_top.sv
// testbench top for the linked slot pool allocator: clock, reset, request and
// result channel drivers with idling phases, and the final verdict
// depends on lspa_pkg, linked_slot_pool_allocator_top and slot_pool_checker
module tb_linked_slot_pool_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lspa_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  action;
  logic [SLOT_NUM_W-1:0] slot_number;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_NUM_W-1:0] granted_slot;
  logic [HEAD_W-1:0]     first_in_use;
  int                    fails;
  int                    pending;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_left      = 0;
  logic hold_arm       = 1'b0;
  logic hold_done      = 1'b0;

  linked_slot_pool_allocator_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .slot_number  (slot_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_slot (granted_slot),
    .first_in_use (first_in_use)
  );

  slot_pool_checker pool_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .slot_number  (slot_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_slot (granted_slot),
    .first_in_use (first_in_use),
    .fails        (fails),
    .pending      (pending)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #12_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stall, plus one long hold-off once armed
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 150;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // offer one request word, with random idle cycles ahead of it
  task automatic send_word(input logic act, input logic [SLOT_NUM_W-1:0] num);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    slot_number <= num;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding result word
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int idle_by_phase [4];
    int stall_by_phase [4];
    int sent;
    int run_len;
    int alloc_pct;
    idle_by_phase  = '{0, 70, 0, 17};
    stall_by_phase = '{0, 0, 70, 17};
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    action      <= ACT_ALLOC;
    slot_number <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, tail and head release, miss, release down to empty
    send_word(ACT_RELEASE, 5'd31);
    repeat (4) send_word(ACT_ALLOC, 5'd31);
    send_word(ACT_RELEASE, 5'd0);
    send_word(ACT_RELEASE, 5'd3);
    send_word(ACT_RELEASE, 5'd31);
    send_word(ACT_RELEASE, 5'd0);
    send_word(ACT_RELEASE, 5'd1);
    send_word(ACT_RELEASE, 5'd2);
    send_word(ACT_RELEASE, 5'd2);
    send_word(ACT_ALLOC, 5'd0);
    send_word(ACT_ALLOC, 5'd0);
    send_word(ACT_RELEASE, 5'd2);
    send_word(ACT_RELEASE, 5'd16);
    drain_results();

    // random runs; each phase opens by filling past exhaustion
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_by_phase[phase];
      recv_stall_pct <= stall_by_phase[phase];
      if (phase == 0) hold_arm <= 1'b1;
      sent      = 0;
      run_len   = 36;
      alloc_pct = 100;
      while (sent < 425) begin
        repeat (run_len) begin
          if ($urandom_range(99) < alloc_pct)
            send_word(ACT_ALLOC, SLOT_NUM_W'($urandom));
          else
            send_word(ACT_RELEASE, SLOT_NUM_W'($urandom));
          sent++;
        end
        run_len = $urandom_range(60, 15);
        case ($urandom_range(4))
          0: alloc_pct = 90;
          1: alloc_pct = 70;
          2: alloc_pct = 50;
          3: alloc_pct = 30;
          default: alloc_pct = 10;
        endcase
      end
      drain_results();
    end

    // let any stray word show up before the verdict
    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
